// ===== src/ttcw_pkg.sv =====
`default_nettype none

package ttcw_pkg;

    localparam int MAX_COLS_DEF = 80;
    localparam int MAX_ROWS_DEF = 25;

    localparam logic [6:0] COLUMNS_RST    = 7'd80;
    localparam logic [4:0] ROWS_RST       = 5'd25;
    localparam logic [7:0] TEXT_ATTR_RST  = 8'd7;
    localparam logic [7:0] ERASE_ATTR_RST = 8'd7;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REG_COLUMNS    = 2'd0;
    localparam logic [1:0] REG_ROWS       = 2'd1;
    localparam logic [1:0] REG_TEXT_ATTR  = 2'd2;
    localparam logic [1:0] REG_ERASE_ATTR = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_beat;

    typedef struct packed {
        logic        cell_written;
        logic [15:0] cell_value;
        logic [6:0]  cell_col;
        logic [4:0]  cell_row;
        logic        scrolled;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [15:0] read_value;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_RD,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/ttcw_screen_ram.sv =====
`default_nettype none

module ttcw_screen_ram #(
    parameter int DEPTH = ttcw_pkg::MAX_COLS_DEF * ttcw_pkg::MAX_ROWS_DEF,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/text_terminal_char_writer_core.sv =====
`default_nettype none

// Text terminal character writer: a screen store of 16-bit cells (attribute high byte,
// character low byte) in one single-port-per-side synchronous memory, plus a cursor.
// One command is worked on at a time; a result beat is held in an output register so the
// next command may be taken while it waits. With more than one row in use a scroll adds
// a copy sweep and a bottom row fill; with a single row only the fill is added. A clear
// sweeps every cell in use; the memory does one cell write per cycle in each sweep. The
// store is not cleared after reset: issue a clear before reading cells that were never
// written.

module text_terminal_char_writer_core #(
    parameter int MAX_COLS = ttcw_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ttcw_pkg::MAX_ROWS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ttcw_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ttcw_pkg::t_out_beat      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [7:0]          i_cfg_data
);

    import ttcw_pkg::*;

    localparam int Depth = MAX_COLS * MAX_ROWS;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

    t_state      r_state, n_state;
    logic [6:0]  r_columns;
    logic [4:0]  r_rows;
    logic [7:0]  r_text_attr;
    logic [7:0]  r_erase_attr;
    logic [6:0]  r_cx;
    logic [4:0]  r_cy;
    logic [4:0]  r_row;
    logic [6:0]  r_col;
    logic [4:0]  r_fend;
    logic        r_wpend;
    logic [AW-1:0] r_waddr;
    logic [7:0]  r_ch;
    logic        r_rd_hit;
    t_out_beat   r_res;
    t_out_beat   r_out;
    logic        r_out_valid;

    logic [6:0]  nc;
    logic [4:0]  nr;
    logic        accept;
    logic        out_load;
    logic        rd_hit;
    logic [6:0]  cx_c;
    logic [4:0]  cy_c;
    logic [7:0]  px;
    logic [5:0]  py;
    logic [7:0]  tab;
    logic        p_wr;
    logic        p_scr;
    logic        col_last;

    logic          m_we;
    logic [AW-1:0] m_waddr;
    logic [15:0]   m_wdata;
    logic          m_re;
    logic [AW-1:0] m_raddr;
    logic [15:0]   m_rdata;

    function automatic logic [AW-1:0] f_addr(input logic [4:0] row, input logic [6:0] col);
        f_addr = AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

    // size in use, saturated
    always_comb begin
        if (r_columns == 7'd0) begin
            nc = 7'd1;
        end else if (int'(r_columns) > MAX_COLS) begin
            nc = 7'(MAX_COLS);
        end else begin
            nc = r_columns;
        end
        if (r_rows == 5'd0) begin
            nr = 5'd1;
        end else if (int'(r_rows) > MAX_ROWS) begin
            nr = 5'(MAX_ROWS);
        end else begin
            nr = r_rows;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign rd_hit     = (i_in_data.read_row < nr) && (i_in_data.read_col < nc);
    assign cx_c       = (r_cx >= nc) ? nc - 7'd1 : r_cx;
    assign cy_c       = (r_cy >= nr) ? nr - 5'd1 : r_cy;
    assign col_last   = (r_col == nc - 7'd1);

    // cursor movement for put character
    always_comb begin
        px    = {1'b0, r_cx};
        py    = {1'b0, r_cy};
        p_wr  = 1'b0;
        tab   = ({1'b0, r_cx} + 8'd4) & 8'hFC;
        case (r_ch)
            CH_NEWLINE: begin
                px = 8'd0;
                py = py + 6'd1;
            end
            CH_RETURN: begin
                px = 8'd0;
            end
            CH_BACKSPACE: begin
                if (r_cx != 7'd0) begin
                    px = px - 8'd1;
                end
            end
            CH_TAB: begin
                if (tab >= {1'b0, nc}) begin
                    px = 8'd0;
                    py = py + 6'd1;
                end else begin
                    px = tab;
                end
            end
            default: begin
                p_wr = 1'b1;
                px   = px + 8'd1;
            end
        endcase
        if (px >= {1'b0, nc}) begin
            px = 8'd0;
            py = py + 6'd1;
        end
        p_scr = (py >= {1'b0, nr});
        if (p_scr) begin
            py = {1'b0, nr} - 6'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.cmd)
                        CMD_PUT:   n_state = S_PUT;
                        CMD_CLEAR: n_state = S_FILL;
                        CMD_READ:  n_state = S_RD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                if (!p_scr) begin
                    n_state = S_DONE;
                end else if (nr > 5'd1) begin
                    n_state = S_SCROLL;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_SCROLL: begin
                if ((r_row == nr - 5'd2) && col_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_FILL;
            S_FILL: begin
                if ((r_row == r_fend) && col_last) begin
                    n_state = S_DONE;
                end
            end
            S_RD: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        m_we    = 1'b0;
        m_waddr = '0;
        m_wdata = '0;
        m_re    = 1'b0;
        m_raddr = '0;
        if (r_wpend) begin
            m_we    = 1'b1;
            m_waddr = r_waddr;
            m_wdata = m_rdata;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in_data.cmd == CMD_READ) && rd_hit) begin
                    m_re    = 1'b1;
                    m_raddr = f_addr(i_in_data.read_row, i_in_data.read_col);
                end
            end
            S_PUT: begin
                if (p_wr) begin
                    m_we    = 1'b1;
                    m_waddr = f_addr(r_cy, r_cx);
                    m_wdata = {r_text_attr, r_ch};
                end
            end
            S_SCROLL: begin
                m_re    = 1'b1;
                m_raddr = f_addr(r_row + 5'd1, r_col);
            end
            S_FILL: begin
                m_we    = 1'b1;
                m_waddr = f_addr(r_row, r_col);
                m_wdata = {r_erase_attr, CH_SPACE};
            end
            default: begin
            end
        endcase
    end

    ttcw_screen_ram #(
        .DEPTH (Depth),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_columns    <= COLUMNS_RST;
            r_rows       <= ROWS_RST;
            r_text_attr  <= TEXT_ATTR_RST;
            r_erase_attr <= ERASE_ATTR_RST;
            r_cx         <= 7'd0;
            r_cy         <= 5'd0;
            r_row        <= 5'd0;
            r_col        <= 7'd0;
            r_fend       <= 5'd0;
            r_wpend      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_COLUMNS:    r_columns    <= i_cfg_data[6:0];
                    REG_ROWS:       r_rows       <= i_cfg_data[4:0];
                    REG_TEXT_ATTR:  r_text_attr  <= i_cfg_data;
                    REG_ERASE_ATTR: r_erase_attr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_wpend <= (r_state == S_SCROLL);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cx   <= cx_c;
                        r_cy   <= cy_c;
                        r_row  <= 5'd0;
                        r_col  <= 7'd0;
                        r_fend <= nr - 5'd1;
                    end
                end
                S_PUT: begin
                    r_cx   <= px[6:0];
                    r_cy   <= py[4:0];
                    r_row  <= 5'd0;
                    r_col  <= 7'd0;
                    r_fend <= nr - 5'd1;
                end
                S_SCROLL, S_FILL: begin
                    if (col_last) begin
                        r_col <= 7'd0;
                        r_row <= r_row + 5'd1;
                    end else begin
                        r_col <= r_col + 7'd1;
                    end
                end
                S_DRAIN: begin
                    r_row <= nr - 5'd1;
                    r_col <= 7'd0;
                end
                default: begin
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= f_addr(r_row, r_col);
        if (accept) begin
            r_ch     <= i_in_data.ch;
            r_rd_hit <= rd_hit;
            r_res    <= '0;
        end
        if (r_state == S_PUT) begin
            r_res.cell_written <= p_wr;
            r_res.scrolled     <= p_scr;
            if (p_wr) begin
                r_res.cell_value <= {r_text_attr, r_ch};
                r_res.cell_col   <= r_cx;
                r_res.cell_row   <= r_cy;
            end
        end
        if (r_state == S_RD) begin
            r_res.read_value <= r_rd_hit ? m_rdata : 16'd0;
        end
        if (out_load) begin
            r_out <= {r_res.cell_written, r_res.cell_value, r_res.cell_col, r_res.cell_row,
                      r_res.scrolled, r_cx, r_cy, r_res.read_value};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_copy_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> (r_state == S_SCROLL || r_state == S_DRAIN))
        else $error("copy write outside scroll sweep");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> !(r_state == S_PUT || r_state == S_FILL))
        else $error("two writes to the screen store in one cycle");

    a_cursor_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_cx < nc && r_cy < nr))
        else $error("cursor outside size at end of command");

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.scrolled) |-> (r_cy == nr - 5'd1))
        else $error("scroll left cursor off the last row");

    a_read_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_re |-> (int'(m_raddr) < Depth))
        else $error("screen store read beyond depth");

endmodule

`default_nettype wire
